[sv/mbrw_pkg.sv]
package mbrw_pkg;

  localparam int NUM_LOCKS   = 16;
  localparam int MAX_WAITERS = 16;
  localparam int COUNT_BITS  = 8;
  localparam int MAX_WAKE    = 16;
  localparam int WIDX_BITS   = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int WCNT_BITS   = $clog2(MAX_WAITERS + 1);
  localparam int NRES_BITS   = $clog2(MAX_WAKE + 2);
  localparam int ENTRY_BITS  = 33;

  typedef enum logic [1:0] {
    KIND_ENTER   = 2'd0,
    KIND_RESERVE = 2'd1,
    KIND_LEAVE   = 2'd2,
    KIND_FREE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_WRONG    = 3'd3,
    ST_FULL     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_ENTERED  = 2'd1;
  localparam logic [1:0] MODE_RESERVED = 2'd2;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  prio;
    logic        excl;
    logic [15:0] mask;
  } waiter_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_wakeup;
    logic [7:0] woken_task;
    logic       last;
  } result_t;

endpackage

[sv/multi_bolt_reader_writer_lock_unit.sv]
// Lock unit for up to 16 shared/exclusive locks with a priority-ordered wait
// queue of 16 entries kept in a one-port-read RAM. Enter and reserve run a
// priority search over the queue and then an insertion shift. Leave and
// free run the wake passes: an exclusive pass and then, if no exclusive
// waiter was left waiting, a shared pass, each of which reads the queue RAM
// one entry at a time and compacts it in place. Results leave through an
// output register; each result of a release is held back until the next
// one is found or the passes end, so that its last flag is known before it
// is offered.
module multi_bolt_reader_writer_lock_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  task_id,
  input  logic [7:0]  priority_req,
  input  logic [15:0] lock_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        is_wakeup,
  output logic [7:0]  woken_task,
  output logic        last
);
  import mbrw_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_FIND  = 11'b00000000100,
    S_FINDW = 11'b00000001000,
    S_SHIFT = 11'b00000010000,
    S_SHW   = 11'b00000100000,
    S_PRES  = 11'b00001000000,
    S_PRD   = 11'b00010000000,
    S_PCHK  = 11'b00100000000,
    S_PEND  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state;
  logic [1:0]  r_kind;
  logic [7:0]  r_task, r_prio;
  logic [NUM_LOCKS-1:0] r_mask;
  logic [WCNT_BITS-1:0] qlen, rd, wr;
  logic [WIDX_BITS-1:0] pos;
  logic pass_excl, res_wait;
  logic [NRES_BITS-1:0] nres;
  waiter_t cur;
  result_t res;
  logic res_pend;
  logic res_ok;

  logic ram_we;
  logic [WIDX_BITS-1:0] ram_wa, ram_ra;
  waiter_t ram_wd, ram_rd;

  logic chk_excl, f_block, f_ovf, r_wrong, do_grant, do_release;
  logic [NUM_LOCKS-1:0] chk_mask;
  logic [1:0] expect_mode;

  mbrw_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_WAITERS)) u_q (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  mbrw_locks u_locks (
    .clk(clk), .rst(rst), .check_excl(chk_excl), .check_mask(chk_mask),
    .fit_block(f_block), .fit_ovf(f_ovf), .rel_expect(expect_mode),
    .rel_wrong(r_wrong), .do_grant(do_grant), .do_release(do_release)
  );

  assign expect_mode = (r_kind == KIND_LEAVE) ? MODE_ENTERED : MODE_RESERVED;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = res_pend && res_ok;
  assign status     = res.status;
  assign is_wakeup  = res.is_wakeup;
  assign woken_task = res.woken_task;
  assign last       = res.last;

  logic fits_now;
  assign fits_now = (state == S_PCHK) && !f_block && !(f_ovf && !cur.excl)
                    && (nres <= NRES_BITS'(MAX_WAKE));

  always_comb begin
    chk_excl   = r_kind[0];
    chk_mask   = '0;
    do_grant   = 1'b0;
    do_release = 1'b0;
    if (state == S_CHECK) begin
      chk_mask = r_mask;
      if (!r_kind[1]) do_grant = !f_block && !f_ovf && !res_pend;
      else do_release = !r_wrong && !res_pend;
    end else if (state == S_PCHK) begin
      chk_excl = cur.excl;
      chk_mask = cur.mask[NUM_LOCKS-1:0];
      do_grant = fits_now && cur.excl == pass_excl && !res_pend;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = pos;
    ram_wd = '{task_id: r_task, prio: r_prio, excl: r_kind[0],
               mask: 16'(r_mask)};
    ram_ra = rd[WIDX_BITS-1:0];
    case (state)
      S_SHW: begin
        if (rd == WCNT_BITS'(pos)) begin
          ram_we = 1'b1;
          ram_wa = pos;
        end else begin
          ram_we = 1'b1;
          ram_wa = rd[WIDX_BITS-1:0];
          ram_wd = ram_rd;
        end
      end
      S_PCHK: begin
        ram_wa = wr[WIDX_BITS-1:0];
        ram_wd = cur;
        ram_we = !(cur.excl == pass_excl && fits_now);
      end
      default: ;
    endcase
    if (state == S_SHIFT) ram_ra = rd[WIDX_BITS-1:0] - 1'b1;
    if (state == S_PRES) ram_ra = '0;
    if (state == S_PCHK) ram_ra = rd[WIDX_BITS-1:0] + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      qlen     <= '0;
      res_pend <= 1'b0;
      res_ok   <= 1'b0;
    end else begin
      if (res_pend && res_ok && out_ready) res_pend <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          r_kind <= kind;
          r_task <= task_id;
          r_prio <= priority_req;
          r_mask <= lock_mask[NUM_LOCKS-1:0];
          state  <= S_CHECK;
        end
        S_CHECK: if (!res_pend) begin
          if (!r_kind[1]) begin
            if (!f_block) begin
              res   <= '{status: f_ovf ? ST_OVERFLOW : ST_GRANTED,
                         is_wakeup: 1'b0, woken_task: '0, last: 1'b1};
              res_pend <= 1'b1;
              res_ok   <= 1'b1;
              state <= S_IDLE;
            end else if (qlen == WCNT_BITS'(MAX_WAITERS)) begin
              res   <= '{status: ST_FULL, is_wakeup: 1'b0, woken_task: '0,
                         last: 1'b1};
              res_pend <= 1'b1;
              res_ok   <= 1'b1;
              state <= S_IDLE;
            end else begin
              rd    <= '0;
              state <= S_FIND;
            end
          end else if (r_wrong) begin
            res   <= '{status: ST_WRONG, is_wakeup: 1'b0, woken_task: '0,
                       last: 1'b1};
            res_pend <= 1'b1;
            res_ok   <= 1'b1;
            state <= S_IDLE;
          end else begin
            res   <= '{status: ST_RELEASED, is_wakeup: 1'b0, woken_task: '0,
                       last: 1'b0};
            res_pend  <= 1'b1;
            res_ok    <= 1'b0;
            nres      <= NRES_BITS'(1);
            pass_excl <= 1'b1;
            res_wait  <= 1'b0;
            state     <= S_PRES;
          end
        end
        S_FIND: begin
          if (rd == qlen) begin
            pos   <= rd[WIDX_BITS-1:0];
            rd    <= qlen;
            state <= S_SHIFT;
          end else state <= S_FINDW;
        end
        S_FINDW: begin
          if (ram_rd.prio > r_prio) begin
            pos   <= rd[WIDX_BITS-1:0];
            rd    <= qlen;
            state <= S_SHIFT;
          end else begin
            rd    <= rd + 1'b1;
            state <= S_FIND;
          end
        end
        S_SHIFT: state <= S_SHW;
        S_SHW: begin
          if (rd == WCNT_BITS'(pos)) begin
            qlen  <= qlen + 1'b1;
            res   <= '{status: ST_BLOCKED, is_wakeup: 1'b0, woken_task: '0,
                       last: 1'b1};
            res_pend <= 1'b1;
            res_ok   <= 1'b1;
            state <= S_IDLE;
          end else begin
            rd    <= rd - 1'b1;
            state <= S_SHIFT;
          end
        end
        S_PRES: begin
          rd    <= '0;
          wr    <= '0;
          state <= S_PRD;
        end
        S_PRD: begin
          if (rd == qlen) state <= S_PEND;
          else state <= S_PCHK;
        end
        S_PCHK: begin
          if (cur.excl == pass_excl && fits_now) begin
            if (!res_pend) begin
              res <= '{status: ST_GRANTED, is_wakeup: 1'b1,
                       woken_task: cur.task_id, last: 1'b0};
              res_pend <= 1'b1;
              res_ok   <= 1'b0;
              nres  <= nres + 1'b1;
              rd    <= rd + 1'b1;
              state <= S_PRD;
            end else res_ok <= 1'b1;
          end else begin
            wr <= wr + 1'b1;
            if (cur.excl == pass_excl) res_wait <= 1'b1;
            rd    <= rd + 1'b1;
            state <= S_PRD;
          end
        end
        S_PEND: begin
          qlen <= wr;
          if (pass_excl && !res_wait) begin
            pass_excl <= 1'b0;
            state     <= S_PRES;
          end else state <= S_EMIT;
        end
        S_EMIT: begin
          res.last <= 1'b1;
          res_ok   <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_PRD && rd != qlen) cur <= ram_rd;
    end
  end

endmodule

[sv/mbrw_ram.sv]
module mbrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[sv/mbrw_locks.sv]
module mbrw_locks (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 check_excl,
  input  logic [mbrw_pkg::NUM_LOCKS-1:0]       check_mask,
  output logic                                 fit_block,
  output logic                                 fit_ovf,
  input  logic [1:0]                           rel_expect,
  output logic                                 rel_wrong,
  input  logic                                 do_grant,
  input  logic                                 do_release
);
  import mbrw_pkg::*;

  logic [1:0]            mode  [NUM_LOCKS];
  logic [COUNT_BITS-1:0] count [NUM_LOCKS];

  always_comb begin
    fit_block = 1'b0;
    fit_ovf   = 1'b0;
    rel_wrong = 1'b0;
    for (int i = 0; i < NUM_LOCKS; i++) begin
      if (check_mask[i]) begin
        if (mode[i] >= MODE_RESERVED || (mode[i] == MODE_ENTERED && check_excl))
          fit_block = 1'b1;
        if (!check_excl && count[i] == {COUNT_BITS{1'b1}}) fit_ovf = 1'b1;
        if (mode[i] != rel_expect) rel_wrong = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
        mode[i]  <= MODE_FREE;
        count[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
        if (check_mask[i]) begin
          if (do_grant) begin
            if (check_excl) begin
              mode[i] <= MODE_RESERVED;
            end else begin
              mode[i]  <= MODE_ENTERED;
              count[i] <= count[i] + 1'b1;
            end
          end else if (do_release) begin
            if (rel_expect == MODE_ENTERED && count[i] > 1) begin
              count[i] <= count[i] - 1'b1;
            end else begin
              count[i] <= '0;
              mode[i]  <= MODE_FREE;
            end
          end
        end
      end
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mbrw_pkg::*;

  class lock_scoreboard;
    logic [1:0] mode [NUM_LOCKS];
    int unsigned shcnt [NUM_LOCKS];
    waiter_t queue_q [$];
    result_t pending_q [$];
    int errors;
    int shown;

    function new();
      for (int i = 0; i < NUM_LOCKS; i++) begin
        mode[i] = MODE_FREE;
        shcnt[i] = 0;
      end
      errors = 0;
      shown = 0;
    endfunction

    function int fits(bit excl, logic [15:0] m);
      int r;
      r = 0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        if (m[i]) begin
          if (mode[i] >= MODE_RESERVED || (mode[i] == MODE_ENTERED && excl)) return 1;
          if (!excl && shcnt[i] >= (1 << COUNT_BITS) - 1) r = 2;
        end
      end
      return r;
    endfunction

    function void take(bit excl, logic [15:0] m);
      for (int i = 0; i < NUM_LOCKS; i++) begin
        if (m[i]) begin
          if (excl) mode[i] = MODE_RESERVED;
          else begin
            mode[i] = MODE_ENTERED;
            shcnt[i] = (shcnt[i] + 1) & ((1 << COUNT_BITS) - 1);
          end
        end
      end
    endfunction

    function void push(logic [2:0] st, bit wk, logic [7:0] t, bit lst);
      result_t r;
      r.status = st;
      r.is_wakeup = wk;
      r.woken_task = t;
      r.last = lst;
      pending_q.push_back(r);
    endfunction

    function void wake(bit excl, ref bit waiting, ref int nres);
      waiter_t kept [$];
      foreach (queue_q[i]) begin
        if (queue_q[i].excl != excl) kept.push_back(queue_q[i]);
        else if (fits(excl, queue_q[i].mask) == 0 && nres < 1 + MAX_WAKE) begin
          take(excl, queue_q[i].mask);
          push(ST_GRANTED, 1'b1, queue_q[i].task_id, 1'b0);
          nres++;
        end else begin
          waiting = 1'b1;
          kept.push_back(queue_q[i]);
        end
      end
      queue_q = kept;
    endfunction

    function void note_request(logic [1:0] k, logic [7:0] t, logic [7:0] p,
                               logic [15:0] m);
      waiter_t w;
      int f, pos, nres;
      bit rw, dummy;
      logic [1:0] want;
      if (k == KIND_ENTER || k == KIND_RESERVE) begin
        f = fits(k == KIND_RESERVE, m);
        if (f == 0) begin
          take(k == KIND_RESERVE, m);
          push(ST_GRANTED, 1'b0, 8'd0, 1'b1);
        end else if (f == 2) push(ST_OVERFLOW, 1'b0, 8'd0, 1'b1);
        else if (queue_q.size() >= MAX_WAITERS) push(ST_FULL, 1'b0, 8'd0, 1'b1);
        else begin
          pos = 0;
          while (pos < queue_q.size() && queue_q[pos].prio <= p) pos++;
          w.task_id = t;
          w.prio = p;
          w.excl = (k == KIND_RESERVE);
          w.mask = m;
          queue_q.insert(pos, w);
          push(ST_BLOCKED, 1'b0, 8'd0, 1'b1);
        end
        return;
      end
      want = (k == KIND_LEAVE) ? MODE_ENTERED : MODE_RESERVED;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        if (m[i] && mode[i] != want) begin
          push(ST_WRONG, 1'b0, 8'd0, 1'b1);
          return;
        end
      end
      for (int i = 0; i < NUM_LOCKS; i++) begin
        if (m[i]) begin
          if (want == MODE_ENTERED && shcnt[i] > 1) shcnt[i]--;
          else begin
            shcnt[i] = 0;
            mode[i] = MODE_FREE;
          end
        end
      end
      push(ST_RELEASED, 1'b0, 8'd0, 1'b0);
      nres = 1;
      rw = 0;
      dummy = 0;
      wake(1'b1, rw, nres);
      if (!rw) wake(1'b0, dummy, nres);
      pending_q[pending_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %p", got);
        end
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected %p actual %p", exp, got);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] kind = 0;
  logic [7:0] task_id = 0;
  logic [7:0] priority_req = 0;
  logic [15:0] lock_mask = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] status;
  logic is_wakeup;
  logic [7:0] woken_task;
  logic last;
  bit calm = 0;

  lock_scoreboard sb = new();

  multi_bolt_reader_writer_lock_unit i_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(kind, task_id, priority_req, lock_mask);
      if (out_valid && out_ready) sb.check_result('{status, is_wakeup, woken_task, last});
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        gap = $urandom_range(1, 18);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send(logic [1:0] k, logic [7:0] t, logic [7:0] p, logic [15:0] m);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    task_id <= t;
    priority_req <= p;
    lock_mask <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return 16'h0001 << $urandom_range(0, 15);
      1: return 16'($urandom_range(1, 65535));
      2: return 16'hFFFF;
      default: return (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    logic [1:0] k;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(KIND_ENTER, 8'd0, 8'd0, 16'h0000);
    send(KIND_LEAVE, 8'd1, 8'd0, 16'h0000);
    send(KIND_FREE, 8'd1, 8'd0, 16'h0001);
    send(KIND_RESERVE, 8'd2, 8'd255, 16'hFFFF);
    send(KIND_ENTER, 8'd255, 8'd10, 16'h0001);
    send(KIND_RESERVE, 8'd3, 8'd10, 16'h8000);
    send(KIND_ENTER, 8'd4, 8'd0, 16'h0002);
    send(KIND_LEAVE, 8'd2, 8'd0, 16'h0001);
    send(KIND_FREE, 8'd2, 8'd0, 16'hFFFF);
    send(KIND_FREE, 8'd3, 8'd0, 16'h8000);
    for (int i = 0; i < 255; i++) send(KIND_ENTER, i[7:0], 8'd0, 16'h4000);
    send(KIND_ENTER, 8'd77, 8'd0, 16'h4000);
    send(KIND_RESERVE, 8'd5, 8'd0, 16'hFFFF);
    for (int i = 0; i < 17; i++) send(KIND_RESERVE, i[7:0], 8'($urandom_range(0, 255)), 16'h4000);
    for (int i = 0; i < 255; i++) send(KIND_LEAVE, 8'd0, 8'd0, 16'h4000);
    send(KIND_FREE, 8'd0, 8'd0, 16'hFFFF);
    for (int i = 0; i < 3; i++) send(KIND_FREE, 8'd0, 8'd0, 16'hFFFF);
    send(KIND_LEAVE, 8'd0, 8'd0, 16'hFFFF);
    for (int n = 0; n < 40; n++) begin
      if (n > 30) calm = 1;
      k = 2'($urandom_range(0, 3));
      send(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_mask());
    end
    in_valid <= 0;
    calm = 1;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
